@@ rtl/utf8v_pkg.sv @@
// Shared types, constants and decode functions for the UTF-8 text validator.
package utf8v_pkg;

  typedef enum logic [1:0] {
    VERDICT_VALID      = 2'd0,
    VERDICT_BAD_LEAD   = 2'd1,
    VERDICT_BAD_CONT   = 2'd2,
    VERDICT_INCOMPLETE = 2'd3
  } verdict_t;

  localparam logic [7:0] BOM_BYTE0 = 8'hEF;
  localparam logic [7:0] BOM_BYTE1 = 8'hBB;
  localparam logic [7:0] BOM_BYTE2 = 8'hBF;

  localparam logic [1:0] BOM_LAST_POS = 2'd2;
  localparam logic [1:0] POS_SATURATED = 2'd3;

  typedef struct packed {
    logic       expect_cont;
    logic [2:0] seq_count;
    verdict_t   latched_error;
    logic [1:0] byte_pos;
    logic       bom_matching;
    logic       bom_found;
  } state_t;

  localparam state_t STATE_RESET = '{
    expect_cont:   1'b0,
    seq_count:     3'd0,
    latched_error: VERDICT_VALID,
    byte_pos:      2'd0,
    bom_matching:  1'b1,
    bom_found:     1'b0
  };

  typedef struct packed {
    logic       bad;
    logic [2:0] followers;
  } lead_info_t;

  // Number of continuation bytes announced by a lead byte, and whether it is a bad lead.
  function automatic lead_info_t lead_decode(input logic [7:0] b);
    lead_info_t info;
    info.bad       = 1'b0;
    info.followers = 3'd0;
    if (b[7] == 1'b0) begin
      info.followers = 3'd0;
    end else if (b[7:5] == 3'b110) begin
      info.followers = 3'd1;
    end else if (b[7:4] == 4'b1110) begin
      info.followers = 3'd2;
    end else if (b[7:3] == 5'b11110) begin
      info.followers = 3'd3;
    end else if (b[7:2] == 6'b111110) begin
      info.followers = 3'd4;
    end else if (b[7:1] == 7'b1111110) begin
      info.followers = 3'd5;
    end else begin
      info.bad = 1'b1;
    end
    return info;
  endfunction

  function automatic logic [7:0] bom_byte_at(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = BOM_BYTE0;
      2'd1:    b = BOM_BYTE1;
      default: b = BOM_BYTE2;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/utf8v_step.sv @@
// Per-byte next-state and verdict logic of the UTF-8 text validator.
module utf8v_step (
  input  utf8v_pkg::state_t   state_cur,
  input  logic [7:0]          text_byte,
  output utf8v_pkg::state_t   state_nxt,
  output logic                is_term,
  output utf8v_pkg::verdict_t verdict,
  output logic [2:0]          missing_bytes
);

  utf8v_pkg::lead_info_t lead;

  always_comb begin
    lead          = utf8v_pkg::lead_decode(text_byte);
    state_nxt     = state_cur;
    is_term       = (text_byte == 8'd0);
    verdict       = utf8v_pkg::VERDICT_VALID;
    missing_bytes = 3'd0;

    if (is_term) begin
      if (state_cur.bom_found) begin
        verdict = utf8v_pkg::VERDICT_VALID;
      end else if (state_cur.latched_error != utf8v_pkg::VERDICT_VALID) begin
        verdict = state_cur.latched_error;
      end else if (state_cur.expect_cont) begin
        verdict       = utf8v_pkg::VERDICT_INCOMPLETE;
        missing_bytes = state_cur.seq_count;
      end
      state_nxt = utf8v_pkg::STATE_RESET;
    end else begin
      // The byte order mark is tracked even after an error is latched.
      if (state_cur.byte_pos != utf8v_pkg::POS_SATURATED) begin
        if (text_byte != utf8v_pkg::bom_byte_at(state_cur.byte_pos)) begin
          state_nxt.bom_matching = 1'b0;
        end else if (state_cur.byte_pos == utf8v_pkg::BOM_LAST_POS &&
                     state_cur.bom_matching) begin
          state_nxt.bom_found = 1'b1;
        end
        state_nxt.byte_pos = state_cur.byte_pos + 2'd1;
      end

      if (state_cur.latched_error == utf8v_pkg::VERDICT_VALID) begin
        if (!state_cur.expect_cont) begin
          if (lead.bad) begin
            state_nxt.latched_error = utf8v_pkg::VERDICT_BAD_LEAD;
          end else if (lead.followers != 3'd0) begin
            state_nxt.expect_cont = 1'b1;
            state_nxt.seq_count   = lead.followers;
          end
        end else if (text_byte[7:6] == 2'b10) begin
          state_nxt.seq_count = state_cur.seq_count - 3'd1;
          if (state_cur.seq_count == 3'd1) begin
            state_nxt.expect_cont = 1'b0;
          end
        end else begin
          state_nxt.latched_error = utf8v_pkg::VERDICT_BAD_CONT;
        end
      end
    end
  end

endmodule

@@ rtl/utf8_text_validator_core.sv @@
// Top level of the UTF-8 text validator: state registers and result register.
// The validator takes one text byte per cycle and keeps up with back-to-back
// transfers; a zero byte ends the text, and its verdict appears on the result
// port in the cycle after the terminator transfer. Every other byte updates
// only the internal state and gives no result. The per-byte logic sits between
// the state registers and a single result register, so the only thing that
// holds off input is a verdict still waiting in that register while out_stall
// is high.
module utf8_text_validator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict,
  output logic [2:0] out_missing_bytes
);

  utf8v_pkg::state_t   state_r;
  utf8v_pkg::state_t   state_nxt;
  logic                is_term;
  utf8v_pkg::verdict_t verdict;
  logic [2:0]          missing;
  logic                in_xfer;
  logic                out_valid_r;
  logic                out_valid_nxt;
  utf8v_pkg::verdict_t verdict_r;
  logic [2:0]          missing_r;

  utf8v_step u_step (
    .state_cur     (state_r),
    .text_byte     (in_text_byte),
    .state_nxt     (state_nxt),
    .is_term       (is_term),
    .verdict       (verdict),
    .missing_bytes (missing)
  );

  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_xfer && is_term) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= utf8v_pkg::STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_term) begin
      verdict_r <= verdict;
      missing_r <= missing;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = verdict_r;
  assign out_missing_bytes = missing_r;

endmodule

@@ rtl/utf8v_checker.sv @@
// Port-level checker for the UTF-8 text validator, bound to the top level.
module utf8v_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_text_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_verdict,
  input logic [2:0] out_missing_bytes
);

  // A pending verdict is not dropped while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Every terminator transfer produces a verdict on the next cycle.
  a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_text_byte == 8'd0 |=> out_valid)
    else $error("terminator gave no verdict");

  // A new verdict only follows a terminator transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && !in_stall && in_text_byte == 8'd0))
    else $error("verdict without terminator");

  // Missing byte count is only reported with an incomplete verdict.
  a_missing_only_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_missing_bytes != 3'd0 |->
      out_verdict == utf8v_pkg::VERDICT_INCOMPLETE)
    else $error("missing bytes with wrong verdict");

  // Reset leaves no verdict pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utf8_text_validator_core utf8v_checker u_utf8v_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_text_byte      (in_text_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_verdict       (out_verdict),
  .out_missing_bytes (out_missing_bytes)
);

@@ tb/utf8_text_validator_checker.sv @@
// Checker for the UTF-8 text validator: predicts every verdict and compares it.
module utf8_text_validator_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_verdict,
  input  logic [2:0] out_missing_bytes,
  output int         mismatches,
  output int         verdicts_owed
);

  typedef struct packed {
    utf8v_pkg::verdict_t verdict;
    logic [2:0]          missing;
  } text_verdict_t;

  text_verdict_t owed_verdicts[$];

  logic                in_sequence;
  logic [2:0]          cont_left;
  utf8v_pkg::verdict_t first_error;
  logic [1:0]          bytes_seen;
  logic                mark_matching;
  logic                mark_found;

  initial begin
    mismatches = 0;
    verdicts_owed = 0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_text_state();
    in_sequence   = 1'b0;
    cont_left     = 3'd0;
    first_error   = utf8v_pkg::VERDICT_VALID;
    bytes_seen    = 2'd0;
    mark_matching = 1'b1;
    mark_found    = 1'b0;
  endtask

  task automatic track_text_byte(input logic [7:0] b);
    text_verdict_t rec;
    logic [7:0]    mark;
    int            followers;
    if (b == 8'h00) begin
      rec.verdict = utf8v_pkg::VERDICT_VALID;
      rec.missing = 3'd0;
      // A leading byte order mark overrides any error or open sequence.
      if (!mark_found) begin
        if (first_error != utf8v_pkg::VERDICT_VALID) begin
          rec.verdict = first_error;
        end else if (in_sequence) begin
          rec.verdict = utf8v_pkg::VERDICT_INCOMPLETE;
          rec.missing = cont_left;
        end
      end
      owed_verdicts.push_back(rec);
      clear_text_state();
    end else begin
      if (bytes_seen != 2'd3) begin
        case (bytes_seen)
          2'd0:    mark = utf8v_pkg::BOM_BYTE0;
          2'd1:    mark = utf8v_pkg::BOM_BYTE1;
          default: mark = utf8v_pkg::BOM_BYTE2;
        endcase
        if (b != mark) begin
          mark_matching = 1'b0;
        end else if (bytes_seen == 2'd2 && mark_matching) begin
          mark_found = 1'b1;
        end
        bytes_seen = bytes_seen + 2'd1;
      end
      if (first_error == utf8v_pkg::VERDICT_VALID) begin
        if (!in_sequence) begin
          casez (b)
            8'b0???????: followers = 0;
            8'b110?????: followers = 1;
            8'b1110????: followers = 2;
            8'b11110???: followers = 3;
            8'b111110??: followers = 4;
            8'b1111110?: followers = 5;
            default:     followers = -1;
          endcase
          if (followers < 0) begin
            first_error = utf8v_pkg::VERDICT_BAD_LEAD;
          end else if (followers > 0) begin
            in_sequence = 1'b1;
            cont_left   = 3'(followers);
          end
        end else if (b[7:6] == 2'b10) begin
          cont_left = cont_left - 3'd1;
          if (cont_left == 3'd0) in_sequence = 1'b0;
        end else begin
          first_error = utf8v_pkg::VERDICT_BAD_CONT;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    text_verdict_t want;
    if (!rst_n) begin
      clear_text_state();
      owed_verdicts.delete();
    end else begin
      // The result for a terminator is registered and never shows at the edge that takes it, so
      // the result side is checked before this edge's input is predicted.
      if (out_valid && !out_stall) begin
        if (owed_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with no text ended", out_verdict));
        end else begin
          want = owed_verdicts.pop_front();
          if (out_verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d, predicted %0d", out_verdict,
                                      want.verdict));
          if (out_missing_bytes !== want.missing)
            report_mismatch($sformatf("missing_bytes %0d, predicted %0d",
                                      out_missing_bytes, want.missing));
        end
      end
      if (in_valid && !in_stall) track_text_byte(in_text_byte);
    end
    verdicts_owed = owed_verdicts.size();
  end

endmodule

@@ tb/utf8_text_validator_core_test.sv @@
// Testbench top for the UTF-8 text validator: clock, reset, text stimulus and verdict.
module utf8_text_validator_core_test;

  localparam int HALF_PERIOD   = 10;
  localparam int RUN_LIMIT     = 12_000_000;
  localparam int TEXT_BYTES    = 1950;
  localparam int LONG_HOLD     = 300;
  localparam int DIRECTED_LEN  = 23;

  // Empty text, mark then bad lead, stray continuation, FE lead, open
  // two-byte sequence, open six-byte sequence, bad continuation, and
  // bytes after a latched bad lead.
  localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
    8'h00,
    8'hEF, 8'hBB, 8'hBF, 8'hFF, 8'h00,
    8'h80, 8'h00,
    8'hFE, 8'h00,
    8'hC3, 8'h00,
    8'hFC, 8'h80, 8'h00,
    8'hE2, 8'h41, 8'h00,
    8'h7F, 8'h01, 8'hFF, 8'hC2, 8'h00
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_text_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_verdict;
  logic [2:0] out_missing_bytes;

  int mismatches;
  int verdicts_owed;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  utf8_text_validator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_missing_bytes(out_missing_bytes)
  );

  utf8_text_validator_checker verdict_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_missing_bytes(out_missing_bytes),
    .mismatches       (mismatches),
    .verdicts_owed    (verdicts_owed)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int idle_cycles();
    if (calm) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 1) == 1) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (verdicts_owed != 0);
  endtask

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_cycles() + 1) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] text_buf[$];
    logic [7:0] b;
    int         n_chars;
    int         len;
    int         pos;
    int         sent;
    int         text_no;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_BYTES[i]) push_byte(DIRECTED_BYTES[i]);
    drain();

    sent    = 0;
    text_no = 0;
    while (sent < TEXT_BYTES) begin
      if (text_no % 8 == 0) calm = ($urandom_range(0, 3) == 0);
      // Long receiver hold-off while texts keep coming, so the input backs up.
      if (text_no == 60) hold_request = 1'b1;
      if (text_no % 40 == 39) drain();

      text_buf.delete();
      case ($urandom_range(0, 15))
        0, 1: begin
          text_buf.push_back(utf8v_pkg::BOM_BYTE0);
          text_buf.push_back(utf8v_pkg::BOM_BYTE1);
          text_buf.push_back(utf8v_pkg::BOM_BYTE2);
        end
        2: begin
          text_buf.push_back(utf8v_pkg::BOM_BYTE0);
          text_buf.push_back(utf8v_pkg::BOM_BYTE1);
          if ($urandom_range(0, 1) == 1) text_buf.push_back(8'($urandom_range(1, 255)));
        end
        default: ;
      endcase

      n_chars = $urandom_range(0, 6);
      repeat (n_chars) begin
        len = $urandom_range(1, 6);
        case (len)
          1:       b = 8'($urandom_range(1, 127));
          2:       b = {3'b110, 5'($urandom)};
          3:       b = {4'b1110, 4'($urandom)};
          4:       b = {5'b11110, 3'($urandom)};
          5:       b = {6'b111110, 2'($urandom)};
          default: b = {7'b1111110, 1'($urandom)};
        endcase
        text_buf.push_back(b);
        repeat (len - 1) text_buf.push_back({2'b10, 6'($urandom)});
      end

      // Break a share of the texts: cut short, overwrite, insert a bad byte, or append a random byte.
      case ($urandom_range(0, 9))
        0: begin
          if (text_buf.size() > 0)
            repeat ($urandom_range(1, text_buf.size())) void'(text_buf.pop_back());
        end
        1: begin
          if (text_buf.size() > 0)
            text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
        end
        2: begin
          pos = $urandom_range(0, text_buf.size());
          case ($urandom_range(0, 2))
            0:       b = {2'b10, 6'($urandom)};
            1:       b = 8'hFE;
            default: b = 8'hFF;
          endcase
          text_buf.insert(pos, b);
        end
        3: text_buf.push_back(8'($urandom_range(1, 255)));
        default: ;
      endcase

      foreach (text_buf[i]) push_byte(text_buf[i]);
      push_byte(8'h00);
      sent += text_buf.size() + 1;
      text_no++;
    end

    in_valid <= 1'b0;
    while (verdicts_owed != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && verdicts_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/utf8v_pkg.sv
rtl/utf8v_step.sv
rtl/utf8_text_validator_core.sv
rtl/utf8v_checker.sv
tb/utf8_text_validator_checker.sv
tb/utf8_text_validator_core_test.sv
